/* hdl/gfsk_pkg.sv */
// ----------------------------------------------------------------------------
// gfsk_pkg
// Shared constants, register indexes, control codes and types of the
// three-bin complex goertzel fsk detector.
// ----------------------------------------------------------------------------
package gfsk_pkg;

   // default widths handed to the top level
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int ACC_WIDTH_DEF    = 48;

   // fixed field widths
   localparam int OUT_WIDTH       = 40;
   localparam int CSR_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int MULB_WIDTH      = CSR_WIDTH + 1;

   // filter bank shape
   localparam int NUM_BINS       = 3;
   localparam int NUM_FILT       = 2 * NUM_BINS;
   localparam int FILT_IDX_WIDTH = 3;
   localparam int BIN_IDX_WIDTH  = 2;

   // fixed point alignment of the recursion and the twiddle term
   localparam int FILT_SHIFT = 14;
   localparam int TWID_SHIFT = 15;

   // sequencer step map
   localparam int STEP_WIDTH     = 5;
   localparam int STEP_XI        = 1;
   localparam int STEP_FILT_LAST = 8;
   localparam int STEP_BIN_FIRST = 8;
   localparam int STEP_ISS_LAST  = 19;
   localparam int STEP_OUT_LAST  = 21;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_SPACE   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_CARRIER = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_MARK    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SINE_SPACE   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SINE_CARRIER = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SINE_MARK    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INV_LENGTH   = 3'd6;

   localparam logic [CSR_WIDTH-1:0] INV_LENGTH_RESET = 16'hFFFF;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_PUB  = 3'b100
   } state_type;

   // multiplier operand a source
   typedef enum logic [1:0] {
      A_XR,
      A_XI,
      A_DLY
   } asel_type;

   // multiplier operand b source
   typedef enum logic [1:0] {
      B_INV,
      B_COEF,
      B_SINE
   } bsel_type;

   // what is done with the product that arrives this cycle
   typedef enum logic [2:0] {
      WB_NONE,
      WB_XR,
      WB_XI,
      WB_FILT,
      WB_LOAD,
      WB_ADD,
      WB_SUB,
      WB_OUT
   } wb_type;

   // sequencer to datapath control
   typedef struct packed {
      logic                      accept;
      logic                      publish;
      asel_type                  a_sel;
      bsel_type                  b_sel;
      logic [FILT_IDX_WIDTH-1:0] rd_idx;
      logic [BIN_IDX_WIDTH-1:0]  bin;
      wb_type                    wb;
      logic [FILT_IDX_WIDTH-1:0] wb_idx;
   } ctl_type;

   // configuration register contents
   typedef struct packed {
      logic [NUM_BINS-1:0][CSR_WIDTH-1:0] coef;
      logic [NUM_BINS-1:0][CSR_WIDTH-1:0] sine;
      logic [CSR_WIDTH-1:0]               inv;
   } cfg_type;

endpackage

/* hdl/gfsk_csr.sv */
// ----------------------------------------------------------------------------
// gfsk_csr
// Configuration register bank: bin coefficients, twiddle sines and the
// reciprocal block length.
// ----------------------------------------------------------------------------
module gfsk_csr (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [gfsk_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [gfsk_pkg::CSR_WIDTH-1:0]           csr_data,
   output gfsk_pkg::cfg_type                        cfg
);

   gfsk_pkg::cfg_type cfg_ff;
   gfsk_pkg::cfg_type cfg_in;

   // registers take a write in every cycle
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode, unknown index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            gfsk_pkg::REG_COEF_SPACE:   cfg_in.coef[0] = csr_data;
            gfsk_pkg::REG_COEF_CARRIER: cfg_in.coef[1] = csr_data;
            gfsk_pkg::REG_COEF_MARK:    cfg_in.coef[2] = csr_data;
            gfsk_pkg::REG_SINE_SPACE:   cfg_in.sine[0] = csr_data;
            gfsk_pkg::REG_SINE_CARRIER: cfg_in.sine[1] = csr_data;
            gfsk_pkg::REG_SINE_MARK:    cfg_in.sine[2] = csr_data;
            gfsk_pkg::REG_INV_LENGTH:   cfg_in.inv     = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         cfg_ff.inv  <= gfsk_pkg::INV_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/gfsk_mul.sv */
// ----------------------------------------------------------------------------
// gfsk_mul
// Shared signed multiplier, accumulator width by seventeen bits, with the
// product registered.
// ----------------------------------------------------------------------------
module gfsk_mul #(
   parameter int ACC_WIDTH = gfsk_pkg::ACC_WIDTH_DEF
) (
   input  logic                                                clock,
   input  logic signed [ACC_WIDTH-1:0]                         mul_a,
   input  logic signed [gfsk_pkg::MULB_WIDTH-1:0]              mul_b,
   output logic signed [ACC_WIDTH+gfsk_pkg::MULB_WIDTH-1:0]    prod
);

   localparam int PW = ACC_WIDTH + gfsk_pkg::MULB_WIDTH;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;

   // exact product, fits the sum of the operand widths
   assign prod_in = PW'(mul_a) * PW'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* hdl/gfsk_seq.sv */
// ----------------------------------------------------------------------------
// gfsk_seq
// Step sequencer: while running, issues one multiply a cycle and tells
// the datapath what to do with the product coming back; owns the handshakes.
// ----------------------------------------------------------------------------
module gfsk_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_last_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gfsk_pkg::ctl_type   ctl
);

   localparam int SW = gfsk_pkg::STEP_WIDTH;

   gfsk_pkg::state_type state_ff;
   gfsk_pkg::state_type state_in;
   logic [SW-1:0]       step_ff;
   logic [SW-1:0]       step_in;
   logic                last_ff;
   logic                last_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   logic [SW-1:0]       rel_iss;
   logic [SW-1:0]       rel_wb;
   logic [SW-1:0]       rel_filt;

   assign req_ready = (state_ff == gfsk_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // step offsets inside the filter and bin phases
   assign rel_iss  = step_ff - SW'(gfsk_pkg::STEP_BIN_FIRST);
   assign rel_wb   = step_ff - SW'(gfsk_pkg::STEP_BIN_FIRST + 1);
   assign rel_filt = step_ff - SW'(gfsk_pkg::STEP_XI + 1);

   // control decode per step
   always_comb begin
      ctl         = '0;
      ctl.a_sel   = gfsk_pkg::A_DLY;
      ctl.b_sel   = gfsk_pkg::B_COEF;
      ctl.wb      = gfsk_pkg::WB_NONE;
      ctl.accept  = req_valid && (state_ff == gfsk_pkg::ST_IDLE);
      ctl.publish = (state_ff == gfsk_pkg::ST_PUB) && (!rsp_valid_ff || rsp_ready);

      if (state_ff == gfsk_pkg::ST_RUN) begin
         // multiply issue
         if (step_ff == '0) begin
            ctl.a_sel = gfsk_pkg::A_XR;
            ctl.b_sel = gfsk_pkg::B_INV;
         end else if (step_ff == SW'(gfsk_pkg::STEP_XI)) begin
            ctl.a_sel = gfsk_pkg::A_XI;
            ctl.b_sel = gfsk_pkg::B_INV;
         end else if (step_ff < SW'(gfsk_pkg::STEP_BIN_FIRST)) begin
            ctl.rd_idx = rel_filt[gfsk_pkg::FILT_IDX_WIDTH-1:0];
            ctl.bin    = rel_filt[gfsk_pkg::BIN_IDX_WIDTH:1];
         end else if (step_ff <= SW'(gfsk_pkg::STEP_ISS_LAST)) begin
            // per bin: r1*coef, i1*sine, i1*coef, r1*sine
            ctl.bin    = rel_iss[3:2];
            ctl.rd_idx = {rel_iss[3:2], rel_iss[0] ^ rel_iss[1]};
            ctl.b_sel  = rel_iss[0] ? gfsk_pkg::B_SINE : gfsk_pkg::B_COEF;
         end

         // product writeback
         if (step_ff == SW'(gfsk_pkg::STEP_XI)) begin
            ctl.wb = gfsk_pkg::WB_XR;
         end else if (step_ff == SW'(gfsk_pkg::STEP_XI + 1)) begin
            ctl.wb = gfsk_pkg::WB_XI;
         end else if (step_ff != '0 && step_ff <= SW'(gfsk_pkg::STEP_FILT_LAST)) begin
            ctl.wb     = gfsk_pkg::WB_FILT;
            ctl.wb_idx = 3'(rel_filt - SW'(1));
         end else if (step_ff > SW'(gfsk_pkg::STEP_FILT_LAST) &&
                      step_ff <= SW'(gfsk_pkg::STEP_OUT_LAST)) begin
            case (rel_wb[1:0])
               2'd0: begin
                  if (rel_wb[3:2] == 2'd0) begin
                     ctl.wb = gfsk_pkg::WB_LOAD;
                  end else begin
                     // imaginary output of the previous bin
                     ctl.wb     = gfsk_pkg::WB_OUT;
                     ctl.wb_idx = {rel_wb[3:2], 1'b0} - 3'd1;
                  end
               end
               2'd1: ctl.wb = gfsk_pkg::WB_ADD;
               2'd2: begin
                  ctl.wb     = gfsk_pkg::WB_OUT;
                  ctl.wb_idx = {rel_wb[3:2], 1'b0};
               end
               2'd3: ctl.wb = gfsk_pkg::WB_SUB;
               default: ctl.wb = gfsk_pkg::WB_NONE;
            endcase
         end
      end
   end

   // state machine
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      rsp_valid_in = ctl.publish | (rsp_valid_ff & ~rsp_ready);
      case (state_ff)
         gfsk_pkg::ST_IDLE: begin
            if (ctl.accept) begin
               state_in = gfsk_pkg::ST_RUN;
               step_in  = '0;
               last_in  = req_last_sample;
            end
         end
         gfsk_pkg::ST_RUN: begin
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(gfsk_pkg::STEP_FILT_LAST) && !last_ff) begin
               state_in = gfsk_pkg::ST_IDLE;
            end else if (step_ff == SW'(gfsk_pkg::STEP_OUT_LAST)) begin
               state_in = gfsk_pkg::ST_PUB;
            end
         end
         gfsk_pkg::ST_PUB: begin
            if (ctl.publish) begin
               state_in = gfsk_pkg::ST_IDLE;
            end
         end
         default: state_in = gfsk_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gfsk_pkg::ST_IDLE;
         step_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/gfsk_dp.sv */
// ----------------------------------------------------------------------------
// gfsk_dp
// Datapath: delay state of the six recursions, operand selection for the
// shared multiplier, twiddle accumulator, saturation and result registers.
// ----------------------------------------------------------------------------
module gfsk_dp #(
   parameter int SAMPLE_WIDTH = gfsk_pkg::SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = gfsk_pkg::ACC_WIDTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  gfsk_pkg::ctl_type                                 ctl,
   input  gfsk_pkg::cfg_type                                 cfg,
   input  logic signed [SAMPLE_WIDTH-1:0]                    req_sample_real,
   input  logic signed [SAMPLE_WIDTH-1:0]                    req_sample_imag,
   input  logic signed [ACC_WIDTH+gfsk_pkg::MULB_WIDTH-1:0]  prod,
   output logic signed [ACC_WIDTH-1:0]                       mul_a,
   output logic signed [gfsk_pkg::MULB_WIDTH-1:0]            mul_b,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]             rsp_space_real,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]             rsp_space_imag,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]             rsp_carrier_real,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]             rsp_carrier_imag,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]             rsp_mark_real,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]             rsp_mark_imag
);

   localparam int AW  = ACC_WIDTH;
   localparam int MBW = gfsk_pkg::MULB_WIDTH;
   localparam int PW  = AW + MBW;
   localparam int ACW = PW + 1;
   localparam int TW  = PW + 2;
   localparam int XW  = SAMPLE_WIDTH + MBW;
   localparam int OW  = gfsk_pkg::OUT_WIDTH;
   localparam int NF  = gfsk_pkg::NUM_FILT;

   // captured sample
   logic signed [SAMPLE_WIDTH-1:0] sreal_ff, sreal_in;
   logic signed [SAMPLE_WIDTH-1:0] simag_ff, simag_in;

   // scaled sample
   logic signed [XW-1:0] xr_ff, xr_in;
   logic signed [XW-1:0] xi_ff, xi_in;

   // recursion state s(n-1), s(n-2)
   logic signed [AW-1:0] d1_ff [NF];
   logic signed [AW-1:0] d1_in [NF];
   logic signed [AW-1:0] d2_ff [NF];
   logic signed [AW-1:0] d2_in [NF];

   // twiddle accumulator and held product for the zero-input step
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0]  hold_ff, hold_in;

   // working outputs and published result
   logic signed [OW-1:0] out_ff [NF];
   logic signed [OW-1:0] out_in [NF];
   logic signed [OW-1:0] rsp_ff [NF];
   logic signed [OW-1:0] rsp_in [NF];

   logic signed [PW-1:0] add_src;
   logic signed [TW-1:0] src_ext;
   logic signed [TW-1:0] x_ext;
   logic signed [TW-1:0] d2_ext;
   logic signed [TW-1:0] sum_t;
   logic signed [AW-1:0] sum_sat;
   logic signed [TW-1:0] acc_ext;
   logic signed [TW-1:0] y_t;
   logic signed [OW-1:0] y_sat;

   // multiplier operand a
   always_comb begin
      case (ctl.a_sel)
         gfsk_pkg::A_XR:  mul_a = AW'(sreal_ff);
         gfsk_pkg::A_XI:  mul_a = AW'(simag_ff);
         gfsk_pkg::A_DLY: mul_a = d1_ff[ctl.rd_idx];
         default:         mul_a = d1_ff[ctl.rd_idx];
      endcase
   end

   // multiplier operand b, reciprocal length taken as unsigned
   always_comb begin
      case (ctl.b_sel)
         gfsk_pkg::B_INV:  mul_b = signed'({1'b0, cfg.inv});
         gfsk_pkg::B_COEF: mul_b = MBW'(signed'(cfg.coef[ctl.bin]));
         gfsk_pkg::B_SINE: mul_b = MBW'(signed'(cfg.sine[ctl.bin]));
         default:          mul_b = MBW'(signed'(cfg.coef[ctl.bin]));
      endcase
   end

   // recursion step: (p >> 14) + x - s2, saturated to the accumulator width
   always_comb begin
      add_src = (ctl.wb == gfsk_pkg::WB_OUT) ? hold_ff : prod;
      src_ext = TW'(add_src) >>> gfsk_pkg::FILT_SHIFT;
      if (ctl.wb == gfsk_pkg::WB_FILT) begin
         x_ext = ctl.wb_idx[0] ? TW'(xi_ff) : TW'(xr_ff);
      end else begin
         x_ext = '0;
      end
      d2_ext = TW'(d2_ff[ctl.wb_idx]);
      sum_t  = src_ext + x_ext - d2_ext;
      if (sum_t[TW-1:AW-1] == {(TW-AW+1){sum_t[TW-1]}}) begin
         sum_sat = sum_t[AW-1:0];
      end else begin
         sum_sat = {sum_t[TW-1], {(AW-1){~sum_t[TW-1]}}};
      end
   end

   // bin output: s(N) - (twiddle sum >> 15), saturated to 40 bits
   always_comb begin
      acc_ext = TW'(acc_ff);
      y_t     = TW'(sum_sat) - (acc_ext >>> gfsk_pkg::TWID_SHIFT);
      if (y_t[TW-1:OW-1] == {(TW-OW+1){y_t[TW-1]}}) begin
         y_sat = y_t[OW-1:0];
      end else begin
         y_sat = {y_t[TW-1], {(OW-1){~y_t[TW-1]}}};
      end
   end

   // product writeback and state update
   always_comb begin
      sreal_in = sreal_ff;
      simag_in = simag_ff;
      xr_in    = xr_ff;
      xi_in    = xi_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      acc_in   = acc_ff;
      hold_in  = hold_ff;
      out_in   = out_ff;
      rsp_in   = rsp_ff;

      if (ctl.accept) begin
         sreal_in = req_sample_real;
         simag_in = req_sample_imag;
      end

      case (ctl.wb)
         gfsk_pkg::WB_NONE: ;
         gfsk_pkg::WB_XR:   xr_in = prod[XW-1:0];
         gfsk_pkg::WB_XI:   xi_in = prod[XW-1:0];
         gfsk_pkg::WB_FILT: begin
            d2_in[ctl.wb_idx] = d1_ff[ctl.wb_idx];
            d1_in[ctl.wb_idx] = sum_sat;
         end
         gfsk_pkg::WB_LOAD: begin
            acc_in  = ACW'(prod);
            hold_in = prod;
         end
         gfsk_pkg::WB_ADD:  acc_in = acc_ff + ACW'(prod);
         gfsk_pkg::WB_SUB:  acc_in = acc_ff - ACW'(prod);
         gfsk_pkg::WB_OUT: begin
            out_in[ctl.wb_idx] = y_sat;
            acc_in             = ACW'(prod);
            hold_in            = prod;
         end
         default: ;
      endcase

      // hand the result over and clear the recursions
      if (ctl.publish) begin
         rsp_in = out_ff;
         d1_in  = '{default: '0};
         d2_in  = '{default: '0};
      end
   end

   // recursion state
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '{default: '0};
         d2_ff <= '{default: '0};
      end else begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sreal_ff <= sreal_in;
      simag_ff <= simag_in;
      xr_ff    <= xr_in;
      xi_ff    <= xi_in;
      acc_ff   <= acc_in;
      hold_ff  <= hold_in;
      out_ff   <= out_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_space_real   = rsp_ff[0];
   assign rsp_space_imag   = rsp_ff[1];
   assign rsp_carrier_real = rsp_ff[2];
   assign rsp_carrier_imag = rsp_ff[3];
   assign rsp_mark_real    = rsp_ff[4];
   assign rsp_mark_imag    = rsp_ff[5];

endmodule

/* hdl/three_bin_goertzel_fsk.sv */
// ----------------------------------------------------------------------------
// three_bin_goertzel_fsk
// Complex goertzel detector for space, carrier and mark bins of an fsk
// signal, six recursions sharing one registered multiplier.
// ----------------------------------------------------------------------------
// ordinary sample: next transaction taken once the sequencer is idle again, one
//   multiply a cycle through the shared multiplier (2 scalings, 6 recursions)
// last sample: 12 more multiplies for the twiddle terms; rsp_valid rises from
//   the publish state, next transaction once the result is published, later
//   while an earlier result still waits for rsp_ready
// reset: synchronous; recursion state, rsp_valid, registers zero, inv_length ones
// ----------------------------------------------------------------------------
module three_bin_goertzel_fsk #(
   parameter int SAMPLE_WIDTH = gfsk_pkg::SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = gfsk_pkg::ACC_WIDTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // sample channel
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]               req_sample_real,
   input  logic signed [SAMPLE_WIDTH-1:0]               req_sample_imag,
   input  logic                                         req_last_sample,
   // result channel
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]        rsp_space_real,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]        rsp_space_imag,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]        rsp_carrier_real,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]        rsp_carrier_imag,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]        rsp_mark_real,
   output logic signed [gfsk_pkg::OUT_WIDTH-1:0]        rsp_mark_imag,
   // register write channel
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [gfsk_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [gfsk_pkg::CSR_WIDTH-1:0]               csr_data
);

   localparam int PW = ACC_WIDTH + gfsk_pkg::MULB_WIDTH;

   gfsk_pkg::cfg_type                     cfg;
   gfsk_pkg::ctl_type                     ctl;
   logic signed [ACC_WIDTH-1:0]           mul_a;
   logic signed [gfsk_pkg::MULB_WIDTH-1:0] mul_b;
   logic signed [PW-1:0]                  prod;

   // configuration registers
   gfsk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // step sequencer
   gfsk_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .ctl             (ctl)
   );

   // shared multiplier
   gfsk_mul #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // recursion state and result path
   gfsk_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACC_WIDTH    (ACC_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .cfg              (cfg),
      .req_sample_real  (req_sample_real),
      .req_sample_imag  (req_sample_imag),
      .prod             (prod),
      .mul_a            (mul_a),
      .mul_b            (mul_b),
      .rsp_space_real   (rsp_space_real),
      .rsp_space_imag   (rsp_space_imag),
      .rsp_carrier_real (rsp_carrier_real),
      .rsp_carrier_imag (rsp_carrier_imag),
      .rsp_mark_real    (rsp_mark_real),
      .rsp_mark_imag    (rsp_mark_imag)
   );

endmodule

/* hdl/gfsk_chk.sv */
// ----------------------------------------------------------------------------
// gfsk_chk
// Port-level checker for the goertzel fsk detector, bound to the top level.
// ----------------------------------------------------------------------------
module gfsk_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_last_sample,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_space_real,
   input logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_space_imag,
   input logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_carrier_real,
   input logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_carrier_imag,
   input logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_mark_real,
   input logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_mark_imag
);

   // busy right after taking a sample
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after a transaction");

   // an ordinary sample frees the block after its fixed step count
   a_plain_sample_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last_sample) |-> ##10 req_ready)
      else $error("ordinary sample did not finish in time");

   // no result straight out of reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_space_real) &&
         $stable(rsp_space_imag) && $stable(rsp_carrier_real) &&
         $stable(rsp_carrier_imag) && $stable(rsp_mark_real) &&
         $stable(rsp_mark_imag)))
      else $error("stalled result changed or dropped");

endmodule

bind three_bin_goertzel_fsk gfsk_chk u_gfsk_chk (.*);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-bin complex goertzel fsk detector. A
// bit-exact software copy of the six recursions, the twiddle stage and the
// saturation predicts every bin bank. Stimulus is a short directed plan
// followed by randomized blocks under changing settings and idle mixes, and a
// resonant burst that drives the accumulators and the outputs into clipping.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW           = gfsk_pkg::SAMPLE_WIDTH_DEF;
   localparam int ACC_W        = gfsk_pkg::ACC_WIDTH_DEF;
   localparam int WIDE         = 96;
   localparam int NUM_REGS     = int'(gfsk_pkg::REG_INV_LENGTH) + 1;
   localparam int DRAIN_CYCLES = 32;
   localparam int STALL_CYCLES = 400;
   localparam int PHASE_ITEMS  = 100;
   localparam logic [gfsk_pkg::CSR_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;

   typedef logic signed [WIDE-1:0] wide_type;
   typedef logic [gfsk_pkg::NUM_FILT-1:0][gfsk_pkg::OUT_WIDTH-1:0] bank_type;

   typedef enum logic {
      ROW_WRITE,
      ROW_SAMPLE
   } row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic [gfsk_pkg::CSR_INDEX_WIDTH-1:0] index;
      logic [gfsk_pkg::CSR_WIDTH-1:0]       data;
      logic [SW-1:0]                        re;
      logic [SW-1:0]                        im;
      logic                                 last;
      logic                                 zero_out;
   } row_type;

   // dut ports
   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic signed [SW-1:0]                  req_sample_real;
   logic signed [SW-1:0]                  req_sample_imag;
   logic                                  req_last_sample;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_space_real;
   logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_space_imag;
   logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_carrier_real;
   logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_carrier_imag;
   logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_mark_real;
   logic signed [gfsk_pkg::OUT_WIDTH-1:0] rsp_mark_imag;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [gfsk_pkg::CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [gfsk_pkg::CSR_WIDTH-1:0]        csr_data;

   // predictor state: settings copy and s(n-1), s(n-2) of the six filters
   logic [gfsk_pkg::CSR_WIDTH-1:0] reg_copy [NUM_REGS];
   logic signed [ACC_W-1:0]        s_one [gfsk_pkg::NUM_FILT];
   logic signed [ACC_W-1:0]        s_two [gfsk_pkg::NUM_FILT];
   bank_type                       expected_banks [$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_req  = 0;
   int error_count   = 0;
   int sample_count  = 0;
   int block_count   = 0;
   int write_count   = 0;
   int checked_count = 0;

   string bank_names [gfsk_pkg::NUM_FILT] = '{"space_real", "space_imag", "carrier_real",
                                    "carrier_imag", "mark_real", "mark_imag"};

   // directed plan: extremes, zero scale, unmapped index, all registers
   row_type plan [35] = '{
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h8000, 1'b1, 1'b1},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b1, 1'b1},
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h8000, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h0001, 16'hFFFF, 1'b1, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_INV_LENGTH, 16'h0000, '0, '0, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h8000, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h5555, 16'hAAAA, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b1, 1'b1},
      '{ROW_WRITE, gfsk_pkg::REG_COEF_SPACE, 16'h7FFF, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_COEF_CARRIER, 16'h8000, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_COEF_MARK, 16'h4000, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_SINE_SPACE, 16'h7FFF, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_SINE_CARRIER, 16'h8000, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_SINE_MARK, 16'h5A82, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_INV_LENGTH, 16'hFFFF, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, REG_UNMAPPED, 16'h0000, '0, '0, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h8000, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h8000, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'hAAAA, 16'h5555, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_COEF_SPACE, 16'h2D41, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_COEF_CARRIER, 16'h0000, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_COEF_MARK, 16'hC000, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_SINE_SPACE, 16'h8000, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_SINE_CARRIER, 16'h0001, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_SINE_MARK, 16'h7FFF, '0, '0, 1'b0, 1'b0},
      '{ROW_WRITE, gfsk_pkg::REG_INV_LENGTH, 16'h0001, '0, '0, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h0001, 16'hFFFF, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'hFFFF, 16'h0001, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h8000, 1'b1, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'h0000, 16'h0000, 1'b1, 1'b1}
   };

   three_bin_goertzel_fsk dut (.*);

   // clip a wide value to a signed field of the given width
   function automatic wide_type clamp(wide_type v, int bits);
      wide_type top;
      wide_type bottom;
      top = {{(WIDE-1){1'b0}}, 1'b1};
      top = (top <<< (bits - 1)) - 1;
      bottom = -top - 1;
      if (v > top) return top;
      if (v < bottom) return bottom;
      return v;
   endfunction

   // one second-order step of one filter: s = x + coef*s1 - s2
   function automatic void recur_step(int f, logic signed [gfsk_pkg::CSR_WIDTH-1:0] coef,
                                      wide_type drive);
      wide_type acc;
      wide_type fit;
      acc = ((WIDE'(s_one[f]) * WIDE'(coef)) >>> gfsk_pkg::FILT_SHIFT) + drive
            - WIDE'(s_two[f]);
      fit = clamp(acc, ACC_W);
      s_two[f] = s_one[f];
      s_one[f] = fit[ACC_W-1:0];
   endfunction

   // advance all six filters by one sample, and on a closing sample flush,
   // rotate by the twiddle and clear; returns 1 when a bank comes out
   function automatic bit predict_sample(logic signed [SW-1:0] re, logic signed [SW-1:0] im,
                                         bit last, output bank_type bank);
      wide_type                              scaled_re;
      wide_type                              scaled_im;
      wide_type                              r1;
      wide_type                              i1;
      wide_type                              twid;
      wide_type                              y;
      logic signed [gfsk_pkg::CSR_WIDTH-1:0] coef;
      logic signed [gfsk_pkg::CSR_WIDTH-1:0] sine;
      bank = '0;
      scaled_re = WIDE'(re) * $signed(WIDE'(reg_copy[gfsk_pkg::REG_INV_LENGTH]));
      scaled_im = WIDE'(im) * $signed(WIDE'(reg_copy[gfsk_pkg::REG_INV_LENGTH]));
      for (int k = 0; k < gfsk_pkg::NUM_BINS; k++) begin
         coef = reg_copy[int'(gfsk_pkg::REG_COEF_SPACE) + k];
         recur_step(2 * k, coef, scaled_re);
         recur_step(2 * k + 1, coef, scaled_im);
      end
      if (!last) return 1'b0;
      // extra zero-input step, then y = s(N) - exp(-jw) * s(N-1)
      for (int k = 0; k < gfsk_pkg::NUM_BINS; k++) begin
         coef = reg_copy[int'(gfsk_pkg::REG_COEF_SPACE) + k];
         sine = reg_copy[int'(gfsk_pkg::REG_SINE_SPACE) + k];
         r1 = WIDE'(s_one[2 * k]);
         i1 = WIDE'(s_one[2 * k + 1]);
         recur_step(2 * k, coef, '0);
         recur_step(2 * k + 1, coef, '0);
         twid = (r1 * WIDE'(coef) + i1 * WIDE'(sine)) >>> gfsk_pkg::TWID_SHIFT;
         y = clamp(WIDE'(s_one[2 * k]) - twid, gfsk_pkg::OUT_WIDTH);
         bank[2 * k] = y[gfsk_pkg::OUT_WIDTH-1:0];
         twid = (i1 * WIDE'(coef) - r1 * WIDE'(sine)) >>> gfsk_pkg::TWID_SHIFT;
         y = clamp(WIDE'(s_one[2 * k + 1]) - twid, gfsk_pkg::OUT_WIDTH);
         bank[2 * k + 1] = y[gfsk_pkg::OUT_WIDTH-1:0];
      end
      for (int f = 0; f < gfsk_pkg::NUM_FILT; f++) begin
         s_one[f] = '0;
         s_two[f] = '0;
      end
      return 1'b1;
   endfunction

   // sample values leaning on the extremes
   function automatic logic [SW-1:0] pick_word();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // block length scale: zero, full, tiny or anything
   function automatic logic [gfsk_pkg::CSR_WIDTH-1:0] pick_scale();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 64));
         default: return 16'($urandom);
      endcase
   endfunction

   // offer one sample transaction, predict it once taken
   task automatic send_sample(logic [SW-1:0] re, logic [SW-1:0] im, bit last, bit known_zero);
      bank_type bank;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_real <= re;
      req_sample_imag <= im;
      req_last_sample <= last;
      do @(posedge clock); while (!req_ready);
      sample_count++;
      if (predict_sample(re, im, last, bank)) begin
         if (known_zero) bank = '0;
         expected_banks.push_back(bank);
         block_count++;
      end
   endtask

   // one register write transaction; valid stays up for a following write
   task automatic write_reg(logic [gfsk_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [gfsk_pkg::CSR_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx <= gfsk_pkg::REG_INV_LENGTH) reg_copy[idx] = data;
      write_count++;
   endtask

   // stop offering until every bank is back, then let the sequencer finish
   task automatic settle_bank();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_banks.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random settings with extremes; sometimes an unmapped write first
   task automatic load_random_settings();
      logic [gfsk_pkg::CSR_WIDTH-1:0] word;
      settle_bank();
      if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED, 16'($urandom));
      for (int r = 0; r < int'(gfsk_pkg::REG_INV_LENGTH); r++) begin
         case ($urandom_range(5))
            0: word = 16'h7FFF;
            1: word = 16'h8000;
            2: word = 16'h0000;
            default: word = 16'($urandom);
         endcase
         write_reg(gfsk_pkg::CSR_INDEX_WIDTH'(r), word);
      end
      write_reg(gfsk_pkg::REG_INV_LENGTH, pick_scale());
      csr_valid <= 1'b0;
   endtask

   // random blocks; optional pause part way through until the result side is empty
   task automatic run_phase(int count, bit short_blocks, int pause_at);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         if (short_blocks) len = $urandom_range(1, 2);
         else if ($urandom_range(3) == 0) len = 1;
         else len = $urandom_range(2, 16);
         for (int n = 0; n < len; n++) begin
            if (sent == pause_at) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (expected_banks.size() != 0);
            end
            send_sample(pick_word(), pick_word(), n == len - 1, 1'b0);
            sent++;
         end
      end
   endtask

   // nyquist resonance at coef -2 drives state and outputs into clipping
   task automatic run_saturation_burst();
      settle_bank();
      write_reg(gfsk_pkg::REG_COEF_SPACE, 16'h8000);
      write_reg(gfsk_pkg::REG_COEF_CARRIER, 16'h8000);
      write_reg(gfsk_pkg::REG_COEF_MARK, 16'h7FFF);
      write_reg(gfsk_pkg::REG_SINE_SPACE, 16'h7FFF);
      write_reg(gfsk_pkg::REG_SINE_CARRIER, 16'h8000);
      write_reg(gfsk_pkg::REG_SINE_MARK, 16'h0000);
      write_reg(gfsk_pkg::REG_INV_LENGTH, 16'hFFFF);
      csr_valid <= 1'b0;
      for (int n = 0; n < 400; n++)
         send_sample(n[0] ? 16'h8000 : 16'h7FFF, n[0] ? 16'h7FFF : 16'h8000, n == 399, 1'b0);
      for (int n = 0; n < 200; n++)
         send_sample(n[0] ? 16'h8000 : 16'h7FFF, 16'h7FFF, n == 199, 1'b0);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: check each transaction, throttle ready
   initial begin : result_sink
      bank_type got;
      bank_type want;
      int       hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_mark_imag, rsp_mark_real, rsp_carrier_imag, rsp_carrier_real,
                   rsp_space_imag, rsp_space_real};
            if (expected_banks.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("result transaction with nothing pending");
            end else begin
               want = expected_banks.pop_front();
               checked_count++;
               for (int f = 0; f < gfsk_pkg::NUM_FILT; f++) begin
                  if (got[f] !== want[f]) begin
                     error_count++;
                     if (error_count <= 10)
                        $display("mismatch %s in bank %0d: expected %0d, got %0d",
                                 bank_names[f], checked_count, $signed(want[f]),
                                 $signed(got[f]));
                  end
               end
            end
         end
         // long hold-off takes priority over random idling
         if (rsp_hold_req > 0) begin
            hold_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // stimulus
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample_real = '0;
      req_sample_imag = '0;
      req_last_sample = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      for (int r = 0; r < NUM_REGS; r++) reg_copy[r] = '0;
      reg_copy[gfsk_pkg::REG_INV_LENGTH] = gfsk_pkg::INV_LENGTH_RESET;
      for (int f = 0; f < gfsk_pkg::NUM_FILT; f++) begin
         s_one[f] = '0;
         s_two[f] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan, under the first idle mix
      send_idle_pct = 9;
      rsp_idle_pct  = 88;
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_WRITE) begin
            if (!csr_valid) settle_bank();
            write_reg(plan[r].index, plan[r].data);
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            send_sample(plan[r].re, plan[r].im, plan[r].last, plan[r].zero_out);
         end
      end

      // random part: three idle mixes, four settings each
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 88 : 0;
         rsp_idle_pct  = (mode == 0) ? 88 : (mode == 1) ? 9 : 0;
         if (mode == 2) run_saturation_burst();
         for (int phase = 0; phase < 4; phase++) begin
            load_random_settings();
            if (phase == 1) rsp_hold_req = STALL_CYCLES;
            run_phase(PHASE_ITEMS, phase == 1, (phase == 2) ? PHASE_ITEMS / 2 : -1);
         end
      end

      settle_bank();
      $display("covered %0d samples in %0d blocks, %0d register writes, %0d banks checked",
               sample_count, block_count, write_count, checked_count);
      $display("idle mixes: light send/heavy stall, the reverse, none; plus long result ",
               "stalls and a resonant clipping burst");
      if (error_count == 0 && expected_banks.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
